/* hdl/motion_limit_checker_core_macros.svh */
// Assertion macros shared by the motion limit checker RTL.
`ifndef MOTION_LIMIT_CHECKER_CORE_MACROS_SVH
`define MOTION_LIMIT_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define MLC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define MLC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/mlc_pkg.sv */
// Types, constants and codes shared by the motion limit checker modules.
package mlc_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int PROD_W     = 2 * DATA_WIDTH;

	// Cycle time resets to one second in the fixed point format.
	localparam logic [DATA_WIDTH-1:0] CT_RESET = DATA_WIDTH'(1) << FRAC_BITS;
	// Full-scale jerk stands for unlimited jerk.
	localparam logic [DATA_WIDTH-1:0] JERK_FULL = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_CHECK_CURRENT     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CHECK_TARGET      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_USE_MIN_VELOCITY  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_USE_MIN_ACCEL     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DISCRETE_DURATION = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CYCLE_TIME        = 3'd5;

	localparam logic [3:0] FAIL_NONE      = 4'd0;
	localparam logic [3:0] FAIL_CYCLE     = 4'd1;
	localparam logic [3:0] FAIL_ACC_LIM   = 4'd2;
	localparam logic [3:0] FAIL_CUR_ACC   = 4'd3;
	localparam logic [3:0] FAIL_TGT_ACC   = 4'd4;
	localparam logic [3:0] FAIL_VEL_LIM   = 4'd5;
	localparam logic [3:0] FAIL_CUR_VEL   = 4'd6;
	localparam logic [3:0] FAIL_TGT_VEL   = 4'd7;
	localparam logic [3:0] FAIL_CUR_OVER  = 4'd8;
	localparam logic [3:0] FAIL_TGT_OVER  = 4'd9;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic                  check_current;
		logic                  check_target;
		logic                  use_min_velocity;
		logic                  use_min_accel;
		logic                  discrete_duration;
		logic [DATA_WIDTH-1:0] cycle_time;
	} cfg_t;

	// One classified axis waiting for the overshoot tests.
	typedef struct packed {
		logic [3:0]            code;
		logic                  need_cur;
		logic                  need_tgt;
		logic [DATA_WIDTH-1:0] mag_c;
		logic [DATA_WIDTH-1:0] d_c;
		logic [DATA_WIDTH-1:0] mag_t;
		logic [DATA_WIDTH-1:0] d_t;
		logic [DATA_WIDTH-2:0] jerk;
		logic                  last;
	} qitem_t;

	typedef struct packed {
		logic busy;
		logic set_failed;
		logic wr;
		logic wr_last;
	} back_status_t;

endpackage

/* hdl/mlc_front.sv */
// Front end: runs the comparison checks and prepares the overshoot operands.
module mlc_front (
	input  mlc_pkg::cfg_t                          cfg,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0]  jerk_limit,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0]  max_accel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0]  min_accel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0]  cur_accel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0]  tgt_accel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0]  cur_vel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0]  tgt_vel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0]  max_vel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0]  min_vel,
	input  logic                                   position_control,
	input  logic                                   last_axis,
	output mlc_pkg::qitem_t                        item
);
	import mlc_pkg::*;

	logic signed [DATA_WIDTH-1:0] amin;
	logic signed [DATA_WIDTH-1:0] vmin;
	logic signed [DATA_WIDTH-1:0] ct;
	logic signed [DATA_WIDTH:0]   diff_c;
	logic signed [DATA_WIDTH:0]   diff_t;
	logic                         jlim;
	logic                         reach;
	logic [3:0]                   code;

	always_comb begin
		ct   = $signed(cfg.cycle_time);
		amin = cfg.use_min_accel ? min_accel : -max_accel;
		vmin = cfg.use_min_velocity ? min_vel : -max_vel;
		jlim = (jerk_limit > 0) && (jerk_limit != $signed(JERK_FULL));
		code  = FAIL_NONE;
		reach = 1'b0;
		if (cfg.discrete_duration && (ct <= 0)) begin
			code = FAIL_CYCLE;
		end else if ((jerk_limit < 0) || (max_accel < 0) || (amin > 0)) begin
			code = FAIL_ACC_LIM;
		end else if (cfg.check_current && ((cur_accel > max_accel) || (cur_accel < amin))) begin
			code = FAIL_CUR_ACC;
		end else if (cfg.check_target && ((tgt_accel > max_accel) || (tgt_accel < amin))) begin
			code = FAIL_TGT_ACC;
		end else if (position_control) begin
			if ((max_vel < 0) || (vmin > 0)) begin
				code = FAIL_VEL_LIM;
			end else if (cfg.check_current && ((cur_vel > max_vel) || (cur_vel < vmin))) begin
				code = FAIL_CUR_VEL;
			end else if (cfg.check_target && ((tgt_vel > max_vel) || (tgt_vel < vmin))) begin
				code = FAIL_TGT_VEL;
			end else begin
				reach = 1'b1;
			end
		end
	end

	// Velocity lies inside its limits whenever a test runs, so the margin is
	// non-negative and fits the unsigned data width.
	always_comb begin
		if (cur_accel > 0) begin
			diff_c = {max_vel[DATA_WIDTH-1], max_vel} - {cur_vel[DATA_WIDTH-1], cur_vel};
		end else begin
			diff_c = {cur_vel[DATA_WIDTH-1], cur_vel} - {vmin[DATA_WIDTH-1], vmin};
		end
		if (tgt_accel < 0) begin
			diff_t = {max_vel[DATA_WIDTH-1], max_vel} - {tgt_vel[DATA_WIDTH-1], tgt_vel};
		end else begin
			diff_t = {tgt_vel[DATA_WIDTH-1], tgt_vel} - {vmin[DATA_WIDTH-1], vmin};
		end
	end

	always_comb begin
		item.code     = code;
		item.need_cur = reach && cfg.check_current && jlim && (cur_accel != 0);
		item.need_tgt = reach && cfg.check_target && jlim && (tgt_accel != 0);
		item.mag_c    = cur_accel[DATA_WIDTH-1] ? DATA_WIDTH'(~cur_accel + 1'b1)
		                                        : DATA_WIDTH'(cur_accel);
		item.mag_t    = tgt_accel[DATA_WIDTH-1] ? DATA_WIDTH'(~tgt_accel + 1'b1)
		                                        : DATA_WIDTH'(tgt_accel);
		item.d_c      = diff_c[DATA_WIDTH-1:0];
		item.d_t      = diff_t[DATA_WIDTH-1:0];
		item.jerk     = jerk_limit[DATA_WIDTH-2:0];
		item.last     = last_axis;
	end

endmodule

/* hdl/mlc_queue.sv */
// Short queue of classified axes between the front end and the back end.
module mlc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  mlc_pkg::qitem_t wr_item,
	input  logic            rd_en,
	output mlc_pkg::qitem_t rd_item,
	output logic            full,
	output logic            empty
);
	import mlc_pkg::*;

	qitem_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= QCNT_W'(count_q + 1'b1);
			end else if (rd_en && !wr_en) begin
				count_q <= QCNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule

/* hdl/mlc_back.sv */
// Back end: overshoot tests on one shared multiplier, set flag and result register.
module mlc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  mlc_pkg::qitem_t       q_item,
	output logic                  q_pop,
	input  logic                  res_pop,
	output logic                  res_valid,
	output logic                  axis_ok,
	output logic                  all_ok,
	output logic [3:0]            fail_code,
	output logic                  last_flag,
	output mlc_pkg::back_status_t status
);
	import mlc_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ   = 3'd1;
	localparam logic [2:0] ST_JD   = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]            state_q;
	logic                  sel_q;
	logic                  res_valid_q;
	logic                  set_failed_q;
	qitem_t                item_q;
	logic [3:0]            code_q;
	logic [PROD_W-1:0]     prod_q;
	logic [PROD_W-1:0]     sq_q;

	logic [DATA_WIDTH-1:0] op_mag;
	logic [DATA_WIDTH-1:0] op_d;
	logic [DATA_WIDTH-1:0] mul_a;
	logic [DATA_WIDTH-1:0] mul_b;
	logic [PROD_W-1:0]     mul;
	logic                  over;
	logic                  out_free;
	logic                  done_wr;
	logic                  fail;
	logic                  skip;

	always_comb begin
		op_mag   = sel_q ? item_q.mag_t : item_q.mag_c;
		op_d     = sel_q ? item_q.d_t : item_q.d_c;
		mul_a    = (state_q == ST_SQ) ? op_mag : {1'b0, item_q.jerk};
		mul_b    = (state_q == ST_SQ) ? op_mag : op_d;
		mul      = mul_a * mul_b;
		// Square of the acceleration against twice jerk times velocity margin.
		over     = {1'b0, sq_q} > {prod_q, 1'b0};
		out_free = !res_valid_q || res_pop;
		done_wr  = (state_q == ST_DONE) && out_free;
		q_pop    = (state_q == ST_IDLE) && !q_empty;
		fail     = (code_q != FAIL_NONE);
		skip     = (q_item.code != FAIL_NONE) || !(q_item.need_cur || q_item.need_tgt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			sel_q        <= 1'b0;
			res_valid_q  <= 1'b0;
			set_failed_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						sel_q   <= !q_item.need_cur;
						state_q <= skip ? ST_DONE : ST_SQ;
					end
				end
				ST_SQ: begin
					state_q <= ST_JD;
				end
				ST_JD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!over && !sel_q && item_q.need_tgt) begin
						sel_q   <= 1'b1;
						state_q <= ST_SQ;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (done_wr) begin
				res_valid_q  <= 1'b1;
				set_failed_q <= item_q.last ? 1'b0 : (set_failed_q | fail);
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
			code_q <= q_item.code;
		end
		if (state_q == ST_SQ) begin
			prod_q <= mul;
		end
		if (state_q == ST_JD) begin
			sq_q   <= prod_q;
			prod_q <= mul;
		end
		if ((state_q == ST_CMP) && over) begin
			code_q <= sel_q ? FAIL_TGT_OVER : FAIL_CUR_OVER;
		end
		if (done_wr) begin
			axis_ok   <= !fail;
			all_ok    <= !(set_failed_q || fail);
			fail_code <= code_q;
			last_flag <= item_q.last;
		end
	end

	assign res_valid         = res_valid_q;
	assign status.busy       = (state_q != ST_IDLE);
	assign status.set_failed = set_failed_q;
	assign status.wr         = done_wr;
	assign status.wr_last    = item_q.last;

endmodule

/* hdl/motion_limit_checker_core.sv */
// Top level of the motion limit checker: configuration registers and block wiring.
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+------------------------------------------
//  axis in   | in        | push / full           | limits, accelerations, velocities, flags
//  result    | out       | pop / empty           | axis_ok, all_ok, fail_code, last_flag
//  config    | in        | cfg_we (no wait)      | cfg_index, cfg_data
//
// An axis with no overshoot test goes through the idle and done states of the back end; each
// test adds the square, jerk product and compare states, on the single multiplier in the back
// end, used for a square and a jerk product per test. Reset clears the queue, the result
// register and the set flag, and loads the configuration defaults. A two-entry queue
// keeps push open while the back end works or a result waits for pop.
module motion_limit_checker_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0]  jerk_limit,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0]  max_accel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0]  min_accel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0]  cur_accel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0]  tgt_accel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0]  cur_vel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0]  tgt_vel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0]  max_vel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0]  min_vel,
	input  logic                                   position_control,
	input  logic                                   last_axis,
	output logic                                   empty,
	input  logic                                   pop,
	output logic                                   axis_ok,
	output logic                                   all_ok,
	output logic [3:0]                             fail_code,
	output logic                                   last_flag,
	input  logic                                   cfg_we,
	input  logic [mlc_pkg::REG_IDX_W-1:0]          cfg_index,
	input  logic [mlc_pkg::DATA_WIDTH-1:0]         cfg_data
);
	import mlc_pkg::*;
	`include "motion_limit_checker_core_macros.svh"

	cfg_t         cfg_q;
	qitem_t       f_item;
	qitem_t       q_head;
	logic         q_full;
	logic         q_empty;
	logic         q_pop;
	logic         res_valid;
	logic         in_take;
	logic         res_take;
	back_status_t bstat;

	assign in_take  = push && !q_full;
	assign res_take = pop && res_valid;
	assign full     = q_full;
	assign empty    = !res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_current     <= 1'b1;
			cfg_q.check_target      <= 1'b1;
			cfg_q.use_min_velocity  <= 1'b0;
			cfg_q.use_min_accel     <= 1'b0;
			cfg_q.discrete_duration <= 1'b0;
			cfg_q.cycle_time        <= CT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHECK_CURRENT:     cfg_q.check_current     <= cfg_data[0];
				REG_CHECK_TARGET:      cfg_q.check_target      <= cfg_data[0];
				REG_USE_MIN_VELOCITY:  cfg_q.use_min_velocity  <= cfg_data[0];
				REG_USE_MIN_ACCEL:     cfg_q.use_min_accel     <= cfg_data[0];
				REG_DISCRETE_DURATION: cfg_q.discrete_duration <= cfg_data[0];
				REG_CYCLE_TIME:        cfg_q.cycle_time        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mlc_front u_front (
		.cfg              (cfg_q),
		.jerk_limit       (jerk_limit),
		.max_accel        (max_accel),
		.min_accel        (min_accel),
		.cur_accel        (cur_accel),
		.tgt_accel        (tgt_accel),
		.cur_vel          (cur_vel),
		.tgt_vel          (tgt_vel),
		.max_vel          (max_vel),
		.min_vel          (min_vel),
		.position_control (position_control),
		.last_axis        (last_axis),
		.item             (f_item)
	);

	mlc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_take),
		.wr_item (f_item),
		.rd_en   (q_pop),
		.rd_item (q_head),
		.full    (q_full),
		.empty   (q_empty)
	);

	mlc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_item    (q_head),
		.q_pop     (q_pop),
		.res_pop   (res_take),
		.res_valid (res_valid),
		.axis_ok   (axis_ok),
		.all_ok    (all_ok),
		.fail_code (fail_code),
		.last_flag (last_flag),
		.status    (bstat)
	);

	// A failing axis must also clear the set flag it reports.
	`MLC_ASSERT_IMP(a_fail_clears_all, !empty && !axis_ok, !all_ok, "failing axis reported all_ok")
	`MLC_ASSERT_IMP(a_code_range, !empty, fail_code <= FAIL_TGT_OVER, "fail_code out of range")
	// The set flag starts afresh once the last axis of a set has been written out.
	`MLC_ASSERT_NXT(a_set_cleared, bstat.wr && bstat.wr_last, !bstat.set_failed, "set flag not cleared")

endmodule

/* verif/mlc_verdict_checker.sv */
// Checker that predicts the motion limit checker verdicts and compares them with the block.
`timescale 1ns / 100ps
module mlc_verdict_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	input  logic                                  full,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0] jerk_limit,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0] max_accel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0] min_accel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0] cur_accel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0] tgt_accel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0] cur_vel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0] tgt_vel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0] max_vel,
	input  logic signed [mlc_pkg::DATA_WIDTH-1:0] min_vel,
	input  logic                                  position_control,
	input  logic                                  last_axis,
	input  logic                                  empty,
	input  logic                                  pop,
	input  logic                                  axis_ok,
	input  logic                                  all_ok,
	input  logic [3:0]                            fail_code,
	input  logic                                  last_flag,
	input  logic                                  cfg_we,
	input  logic [mlc_pkg::REG_IDX_W-1:0]         cfg_index,
	input  logic [mlc_pkg::DATA_WIDTH-1:0]        cfg_data,
	output int                                    fail_count,
	output int                                    pending,
	output logic [15:0]                           codes_seen
);
	import mlc_pkg::*;

	typedef logic signed [DATA_WIDTH-1:0] q_t;
	typedef logic [DATA_WIDTH:0]          span_t;
	typedef logic [2*DATA_WIDTH+3:0]      wide_t;

	typedef struct packed {
		logic       axis_ok;
		logic       all_ok;
		logic [3:0] code;
		logic       last;
	} verdict_t;

	verdict_t   verdict_q[$];
	verdict_t   due;
	cfg_t       limits_cfg;
	logic       set_failed;
	logic [3:0] code;

	function automatic span_t magnitude(input q_t v);
		span_t x;
		x = {v[DATA_WIDTH-1], v};
		return (v < 0) ? -x : x;
	endfunction

	// Room left between two values; the callers only pass ordered pairs.
	function automatic span_t gap(input q_t hi, input q_t lo);
		return {hi[DATA_WIDTH-1], hi} - {lo[DATA_WIDTH-1], lo};
	endfunction

	// Braking from acceleration magnitude m at jerk j needs m*m/(2j) of velocity room d.
	function automatic logic overshoots(input span_t m, input logic [DATA_WIDTH-1:0] j,
			input span_t d);
		wide_t sq;
		wide_t room;
		sq   = wide_t'(m) * wide_t'(m);
		room = (wide_t'(j) * wide_t'(d)) << 1;
		return sq > room;
	endfunction

	function automatic logic [3:0] classify_axis(input cfg_t c, input q_t jerk, input q_t amax,
			input q_t amin_in, input q_t a0, input q_t af, input q_t v0, input q_t vf,
			input q_t vmax, input q_t vmin_in, input logic pos_ctl);
		q_t   amin;
		q_t   vmin;
		logic jlim;
		if (c.discrete_duration && $signed(c.cycle_time) <= 0)
			return FAIL_CYCLE;
		if (jerk < 0 || amax < 0)
			return FAIL_ACC_LIM;
		amin = c.use_min_accel ? amin_in : -amax;
		if (amin > 0)
			return FAIL_ACC_LIM;
		if (c.check_current && (a0 > amax || a0 < amin))
			return FAIL_CUR_ACC;
		if (c.check_target && (af > amax || af < amin))
			return FAIL_TGT_ACC;
		if (!pos_ctl)
			return FAIL_NONE;
		if (vmax < 0)
			return FAIL_VEL_LIM;
		vmin = c.use_min_velocity ? vmin_in : -vmax;
		if (vmin > 0)
			return FAIL_VEL_LIM;
		if (c.check_current && (v0 > vmax || v0 < vmin))
			return FAIL_CUR_VEL;
		if (c.check_target && (vf > vmax || vf < vmin))
			return FAIL_TGT_VEL;
		// Zero jerk and full-scale (unlimited) jerk both skip the braking tests.
		jlim = (jerk > 0) && (jerk != JERK_FULL);
		if (c.check_current && jlim) begin
			if (a0 > 0 && overshoots(magnitude(a0), jerk, gap(vmax, v0)))
				return FAIL_CUR_OVER;
			if (a0 < 0 && overshoots(magnitude(a0), jerk, gap(v0, vmin)))
				return FAIL_CUR_OVER;
		end
		if (c.check_target && jlim) begin
			if (af < 0 && overshoots(magnitude(af), jerk, gap(vmax, vf)))
				return FAIL_TGT_OVER;
			if (af > 0 && overshoots(magnitude(af), jerk, gap(vf, vmin)))
				return FAIL_TGT_OVER;
		end
		return FAIL_NONE;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_cfg = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, CT_RESET};
			set_failed = 1'b0;
			fail_count = 0;
			codes_seen = '0;
			verdict_q.delete();
		end else begin
			// A result popped now was predicted at an earlier edge, so check before predicting.
			if (pop && !empty) begin
				if (verdict_q.size() == 0) begin
					$error("result transaction with no axis waiting, fail_code %0d", fail_code);
					fail_count++;
				end else begin
					due = verdict_q.pop_front();
					codes_seen[fail_code] = 1'b1;
					if (axis_ok !== due.axis_ok) begin
						$error("axis_ok: expected %0b, actual %0b", due.axis_ok, axis_ok);
						fail_count++;
					end
					if (all_ok !== due.all_ok) begin
						$error("all_ok: expected %0b, actual %0b", due.all_ok, all_ok);
						fail_count++;
					end
					if (fail_code !== due.code) begin
						$error("fail_code: expected %0d, actual %0d", due.code, fail_code);
						fail_count++;
					end
					if (last_flag !== due.last) begin
						$error("last_flag: expected %0b, actual %0b", due.last, last_flag);
						fail_count++;
					end
				end
			end
			if (push && !full) begin
				code = classify_axis(limits_cfg, jerk_limit, max_accel, min_accel, cur_accel,
					tgt_accel, cur_vel, tgt_vel, max_vel, min_vel, position_control);
				if (code != FAIL_NONE)
					set_failed = 1'b1;
				due = '{code == FAIL_NONE, !set_failed, code, last_axis};
				verdict_q.push_back(due);
				if (last_axis)
					set_failed = 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_CHECK_CURRENT:     limits_cfg.check_current     = cfg_data[0];
					REG_CHECK_TARGET:      limits_cfg.check_target      = cfg_data[0];
					REG_USE_MIN_VELOCITY:  limits_cfg.use_min_velocity  = cfg_data[0];
					REG_USE_MIN_ACCEL:     limits_cfg.use_min_accel     = cfg_data[0];
					REG_DISCRETE_DURATION: limits_cfg.discrete_duration = cfg_data[0];
					REG_CYCLE_TIME:        limits_cfg.cycle_time        = cfg_data;
					default: ;
				endcase
			end
		end
		pending = verdict_q.size();
	end

endmodule

/* verif/tb_motion_limit_checker_core.sv */
// Testbench top for the motion limit checker: clock, reset, stimulus and final verdict.
`timescale 1ns / 100ps
module tb_motion_limit_checker_core;
	import mlc_pkg::*;

	localparam int W            = DATA_WIDTH;
	localparam int RANDOM_ITEMS = 1750;
	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 12;

	typedef logic signed [W-1:0] q_t;

	localparam q_t Q_ONE = 65536;
	localparam q_t Q_MAX = 32'h7fffffff;
	localparam q_t Q_MIN = 32'h80000000;
	localparam q_t A4    = 4 * 65536;
	localparam q_t V8    = 8 * 65536;

	typedef struct packed {
		q_t   jerk;
		q_t   amax;
		q_t   amin;
		q_t   a0;
		q_t   af;
		q_t   v0;
		q_t   vf;
		q_t   vmax;
		q_t   vmin;
		logic pos_ctl;
		logic last;
	} axis_t;

	logic                 clk              = 1'b0;
	logic                 arst_n           = 1'b0;
	logic                 push             = 1'b0;
	q_t                   jerk_limit       = '0;
	q_t                   max_accel        = '0;
	q_t                   min_accel        = '0;
	q_t                   cur_accel        = '0;
	q_t                   tgt_accel        = '0;
	q_t                   cur_vel          = '0;
	q_t                   tgt_vel          = '0;
	q_t                   max_vel          = '0;
	q_t                   min_vel          = '0;
	logic                 position_control = 1'b0;
	logic                 last_axis        = 1'b0;
	logic                 pop              = 1'b0;
	logic                 cfg_we           = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index        = '0;
	logic [W-1:0]         cfg_data         = '0;

	wire                  full;
	wire                  empty;
	wire                  axis_ok;
	wire                  all_ok;
	wire [3:0]            fail_code;
	wire                  last_flag;
	int                   fail_count;
	int                   pending;
	logic [15:0]          codes_seen;

	int send_idle     = 0;
	int recv_idle     = 0;
	int hold_asks     = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int items_sent    = 0;
	int results_taken = 0;
	int phases_run    = 0;
	int quiet_cycles  = 0;

	cfg_t cur_cfg = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, CT_RESET};
	cfg_t phase_cfg [8] = '{
		'{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, CT_RESET},
		'{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 32'h00000001},
		'{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 32'h7fffffff},
		'{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 32'h00000000},
		'{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 32'h80000000},
		'{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 32'hffffffff},
		'{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 32'h00001000},
		'{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, CT_RESET}
	};
	int phase_items [8] = '{280, 280, 280, 40, 40, 280, 270, 280};

	motion_limit_checker_core i_dut (.*);

	mlc_verdict_checker i_checker (.*);

	always #6 clk = ~clk;

	// The receiver side: random pops, or a long hold-off whenever one is asked for.
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				results_taken <= results_taken + 1;
			if ((push && !full) || (pop && !empty)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic axis_t make_axis(input q_t jerk, input q_t amax, input q_t amin,
			input q_t a0, input q_t af, input q_t v0, input q_t vf, input q_t vmax,
			input q_t vmin, input logic pos_ctl, input logic last);
		return '{jerk, amax, amin, a0, af, v0, vf, vmax, vmin, pos_ctl, last};
	endfunction

	// Non-negative value whose bit length is spread evenly, so small and huge both occur.
	function automatic q_t rand_mag();
		return q_t'($urandom() >> $urandom_range(31, 1));
	endfunction

	// Value in [lo, hi]; half of the picks stay within a random distance of one end.
	function automatic q_t pick_in(input q_t lo, input q_t hi);
		longint          span;
		longint          lim;
		longint unsigned r;
		longint unsigned off;
		span = longint'(hi) - longint'(lo) + 1;
		lim  = longint'(1) << $urandom_range(30, 0);
		r    = {$urandom(), $urandom()};
		if ($urandom_range(1) && lim < span)
			span = lim;
		off = r % $unsigned(span);
		if ($urandom_range(1))
			return q_t'(longint'(hi) - longint'(off));
		return q_t'(longint'(lo) + longint'(off));
	endfunction

	// An axis that mostly sits inside its limits, so the velocity and braking checks are hit.
	function automatic axis_t plausible_axis(input cfg_t c);
		axis_t a;
		q_t    lo_a;
		q_t    lo_v;
		case ($urandom_range(9))
			0:       a.jerk = '0;
			1:       a.jerk = q_t'(JERK_FULL);
			default: a.jerk = rand_mag();
		endcase
		a.amax = rand_mag();
		a.amin = -rand_mag();
		a.vmax = rand_mag();
		a.vmin = -rand_mag();
		lo_a = c.use_min_accel ? a.amin : -a.amax;
		lo_v = c.use_min_velocity ? a.vmin : -a.vmax;
		a.a0 = pick_in(lo_a, a.amax);
		a.af = pick_in(lo_a, a.amax);
		a.v0 = pick_in(lo_v, a.vmax);
		a.vf = pick_in(lo_v, a.vmax);
		a.pos_ctl = ($urandom_range(9) != 0);
		a.last    = ($urandom_range(3) == 0);
		// Now and then one field is spoilt to break the axis at a random check.
		if ($urandom_range(7) == 0)
			a[2 + W * $urandom_range(8) +: W] = $urandom();
		return a;
	endfunction

	function automatic axis_t scrambled_axis();
		axis_t a;
		for (int k = 0; k < 9; k++)
			a[2 + W * k +: W] = $urandom();
		a[1:0] = 2'($urandom_range(3));
		return a;
	endfunction

	task automatic send_axis(input axis_t a);
		if (items_sent < RANDOM_ITEMS / 3) begin
			send_idle = 22;
			recv_idle = 50;
		end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
			send_idle = 50;
			recv_idle = 22;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push             <= 1'b1;
		jerk_limit       <= a.jerk;
		max_accel        <= a.amax;
		min_accel        <= a.amin;
		cur_accel        <= a.a0;
		tgt_accel        <= a.af;
		cur_vel          <= a.v0;
		tgt_vel          <= a.vf;
		max_vel          <= a.vmax;
		min_vel          <= a.vmin;
		position_control <= a.pos_ctl;
		last_axis        <= a.last;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// Stops offering axes until every verdict has been taken and the back end is quiet.
	task automatic drain();
		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
	endtask

	task automatic load_config(input cfg_t c);
		write_reg(REG_CHECK_CURRENT, W'({$urandom(), c.check_current}));
		write_reg(REG_CHECK_TARGET, W'({$urandom(), c.check_target}));
		write_reg(REG_USE_MIN_VELOCITY, W'({$urandom(), c.use_min_velocity}));
		write_reg(REG_USE_MIN_ACCEL, W'({$urandom(), c.use_min_accel}));
		write_reg(REG_DISCRETE_DURATION, W'({$urandom(), c.discrete_duration}));
		write_reg(REG_CYCLE_TIME, c.cycle_time);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : stimulus
		repeat (7)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed axes under the reset configuration.
		send_axis(make_axis(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
		send_axis(make_axis(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1, 1));
		send_axis(make_axis(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1, 0));
		send_axis(make_axis(-1, -1, -1, -1, -1, -1, -1, -1, -1, 1, 1));
		send_axis(make_axis(Q_ONE, -Q_ONE, 0, 0, 0, 0, 0, V8, 0, 1, 0));
		send_axis(make_axis(Q_ONE, A4, 0, A4 + 1, 0, 0, 0, V8, 0, 1, 0));
		send_axis(make_axis(Q_ONE, A4, 0, -A4 - 1, 0, 0, 0, V8, 0, 1, 0));
		send_axis(make_axis(Q_ONE, A4, 0, 0, A4 + 1, 0, 0, V8, 0, 1, 0));
		send_axis(make_axis(Q_ONE, A4, 0, 0, -A4 - 1, 0, 0, V8, 0, 1, 1));
		send_axis(make_axis(Q_ONE, A4, 0, 0, 0, 0, 0, -1, 0, 1, 0));
		send_axis(make_axis(Q_ONE, A4, 0, 0, 0, 0, 0, -1, 0, 0, 1));
		send_axis(make_axis(Q_ONE, A4, 0, 0, 0, V8 + 1, 0, V8, 0, 1, 0));
		send_axis(make_axis(Q_ONE, A4, 0, 0, 0, -V8 - 1, 0, V8, 0, 1, 0));
		send_axis(make_axis(Q_ONE, A4, 0, 0, 0, 0, V8 + 1, V8, 0, 1, 0));
		send_axis(make_axis(Q_ONE, A4, 0, 0, 0, 0, -V8 - 1, V8, 0, 1, 1));
		// Braking overshoot in each direction, for the current and the target state.
		send_axis(make_axis(Q_ONE, A4, 0, 2 * Q_ONE, 0, V8 - 1, 0, V8, 0, 1, 0));
		send_axis(make_axis(Q_ONE, A4, 0, -2 * Q_ONE, 0, -V8 + 1, 0, V8, 0, 1, 0));
		send_axis(make_axis(Q_ONE, A4, 0, 0, -2 * Q_ONE, 0, V8 - 1, V8, 0, 1, 0));
		send_axis(make_axis(Q_ONE, A4, 0, 0, 2 * Q_ONE, 0, -V8 + 1, V8, 0, 1, 1));
		// Exactly enough braking room passes; one step less fails.
		send_axis(make_axis(Q_ONE, A4, 0, 2 * Q_ONE, 0, V8 - 2 * Q_ONE, 0, V8, 0, 1, 0));
		send_axis(make_axis(Q_ONE, A4, 0, 2 * Q_ONE, 0, V8 - 2 * Q_ONE + 1, 0, V8, 0, 1, 1));
		// Unlimited jerk, zero jerk and velocity control all skip the braking tests.
		send_axis(make_axis(Q_MAX, A4, 0, 2 * Q_ONE, 0, V8 - 1, 0, V8, 0, 1, 0));
		send_axis(make_axis(0, A4, 0, 2 * Q_ONE, 0, V8 - 1, 0, V8, 0, 1, 0));
		send_axis(make_axis(Q_ONE, A4, 0, 2 * Q_ONE, 0, V8 - 1, 0, V8, 0, 0, 1));
		drain();

		for (int p = 0; p < 8; p++) begin
			load_config(phase_cfg[p]);
			cur_cfg = phase_cfg[p];
			phases_run++;
			for (int k = 0; k < phase_items[p]; k++) begin
				// Stall the receiver for a long stretch so the block fills and raises full.
				if (k == 100)
					hold_asks++;
				if ($urandom_range(4) != 0)
					send_axis(plausible_axis(cur_cfg));
				else
					send_axis(scrambled_axis());
			end
			drain();
		end

		$display("Sent %0d axes over %0d configuration phases and directed cases; %0d verdicts.",
			items_sent, phases_run, results_taken);
		$display("Fail codes seen (one bit per code, code 0 rightmost): %b; long stalls: %0d.",
			codes_seen[9:0], hold_asks);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
